// ----- design/bnp_pkg.sv -----
// ----------------------------------------------------------------------------
// bnp_pkg: shared types and constants for the BGP NLRI prefix parser
// Parse phases, result status codes, family width limits and the result word.
// ----------------------------------------------------------------------------
package bnp_pkg;

    typedef enum logic [1:0] {
        PH_START  = 2'd0,
        PH_PATHID = 2'd1,
        PH_WIDTH  = 2'd2,
        PH_PREFIX = 2'd3
    } t_phase;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_TRUNC    = 2'd1,
        ST_BADWIDTH = 2'd2
    } t_status;

    typedef enum logic {
        CFG_ADDRESS_FAMILY = 1'b0,
        CFG_PATH_IDS       = 1'b1
    } t_cfg_idx;

    localparam logic [7:0] MAX_WIDTH_V4 = 8'd32;
    localparam logic [7:0] MAX_WIDTH_V6 = 8'd128;
    localparam logic [4:0] PATH_ID_BYTES = 5'd4;

    typedef struct packed {
        logic [31:0] path_id;
        logic [7:0]  prefix_width;
        logic [63:0] prefix_high;
        logic [63:0] prefix_low;
        logic [1:0]  status;
        logic        end_of_buffer;
    } t_result;

endpackage

// ----- design/bnp_in_if.sv -----
// ----------------------------------------------------------------------------
// bnp_in_if: NLRI byte channel
// Valid/ready channel carrying one buffer byte and its last-byte flag.
// ----------------------------------------------------------------------------
interface bnp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

// ----- design/bnp_out_if.sv -----
// ----------------------------------------------------------------------------
// bnp_out_if: parsed prefix channel
// Valid/ready channel carrying one parsed prefix or error report.
// ----------------------------------------------------------------------------
interface bnp_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] path_id;
    logic [7:0]  prefix_width;
    logic [63:0] prefix_high;
    logic [63:0] prefix_low;
    logic [1:0]  status;
    logic        end_of_buffer;

    modport source (output valid, output path_id, output prefix_width, output prefix_high,
                    output prefix_low, output status, output end_of_buffer, input ready);
    modport sink   (input valid, input path_id, input prefix_width, input prefix_high,
                    input prefix_low, input status, input end_of_buffer, output ready);
endinterface

// ----- design/bgp_nlri_prefix_parser_top.sv -----
// ----------------------------------------------------------------------------
// bgp_nlri_prefix_parser_top: BGP NLRI prefix walker with path identifier support
//
//   channel   dir  payload                                   handshake
//   i_nlri    in   data_byte[7:0], last_byte                 valid/ready
//   o_prefix  out  path_id, prefix_width, prefix_high/low,   valid/ready
//                  status[1:0], end_of_buffer
//   i_cfg_*   in   idx 0 address_family, idx 1 path ids on   write enable
//
// One byte is taken per cycle while ready is high; the parse state updates at the
// accepting edge and a result, if any, is visible on o_prefix in the following cycle.
// The result register frees as it is read, so a byte is accepted while a
// waiting result is taken in the same cycle; ready drops only while a result
// is held by the consumer. Synchronous reset returns to the start phase.
// ----------------------------------------------------------------------------
module bgp_nlri_prefix_parser_top
    import bnp_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_idx,
    input  logic        i_cfg_wdata,
    bnp_in_if.sink      i_nlri,
    bnp_out_if.source   o_prefix
);

    logic         r_address_family;
    logic         r_path_ids_on;

    t_phase       r_phase,         n_phase;
    logic [4:0]   r_count,         n_count;
    logic [31:0]  r_path_id,       n_path_id;
    logic [7:0]   r_width,         n_width;
    logic [127:0] r_prefix,        n_prefix;
    logic         r_discarding,    n_discarding;

    logic         r_out_valid;
    t_result      r_out;

    logic         w_ready;
    logic         w_accept;
    logic         w_has_result;
    t_status      w_status;
    logic [7:0]   w_byte;
    logic         w_last;
    logic [7:0]   w_max_width;
    logic [8:0]   w_width_round;
    logic [4:0]   w_need;
    logic [3:0]   w_slot;
    logic [4:0]   w_count_inc;
    t_result      w_result;

    assign w_ready  = !r_out_valid || o_prefix.ready;
    assign w_accept = i_nlri.valid && w_ready;
    assign i_nlri.ready = w_ready;
    assign w_byte = i_nlri.data_byte;
    assign w_last = i_nlri.last_byte;

    assign w_max_width   = r_address_family ? MAX_WIDTH_V6 : MAX_WIDTH_V4;
    assign w_width_round = {1'b0, r_width} + 9'd7;
    assign w_need        = w_width_round[7:3];
    assign w_slot        = r_count[3:0];
    assign w_count_inc   = r_count + 5'd1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_address_family <= 1'b0;
            r_path_ids_on    <= 1'b0;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_ADDRESS_FAMILY: r_address_family <= i_cfg_wdata;
                CFG_PATH_IDS:       r_path_ids_on    <= i_cfg_wdata;
                default:            r_path_ids_on    <= r_path_ids_on;
            endcase
        end
    end

    always_comb begin
        n_phase      = r_phase;
        n_count      = r_count;
        n_path_id    = r_path_id;
        n_width      = r_width;
        n_prefix     = r_prefix;
        n_discarding = r_discarding;
        w_has_result = 1'b0;
        w_status     = ST_OK;

        if (r_discarding) begin
            if (w_last) begin
                n_discarding = 1'b0;
                n_phase      = PH_START;
            end
        end else begin
            case (r_phase)
                PH_START: begin
                    n_path_id = '0;
                    n_width   = '0;
                    n_prefix  = '0;
                    n_count   = '0;
                    if (r_path_ids_on) begin
                        n_path_id = {24'd0, w_byte};
                        n_count   = 5'd1;
                        n_phase   = PH_PATHID;
                    end else begin
                        n_width = w_byte;
                        if (w_byte > w_max_width) begin
                            w_has_result = 1'b1;
                            w_status     = ST_BADWIDTH;
                        end else if (w_byte == 8'd0) begin
                            w_has_result = 1'b1;
                            n_phase      = PH_START;
                        end else begin
                            n_phase = PH_PREFIX;
                        end
                    end
                end
                PH_PATHID: begin
                    n_path_id = {r_path_id[23:0], w_byte};
                    n_count   = w_count_inc;
                    if (w_count_inc >= PATH_ID_BYTES) begin
                        n_count = '0;
                        n_phase = PH_WIDTH;
                    end
                end
                PH_WIDTH: begin
                    n_width = w_byte;
                    if (w_byte > w_max_width) begin
                        w_has_result = 1'b1;
                        w_status     = ST_BADWIDTH;
                    end else if (w_byte == 8'd0) begin
                        w_has_result = 1'b1;
                        n_phase      = PH_START;
                    end else begin
                        n_count = '0;
                        n_phase = PH_PREFIX;
                    end
                end
                PH_PREFIX: begin
                    // slot 0 lands in the top byte of the 128-bit store
                    n_prefix[{~w_slot, 3'b000} +: 8] = r_prefix[{~w_slot, 3'b000} +: 8] | w_byte;
                    n_count = w_count_inc;
                    if (w_count_inc >= w_need) begin
                        w_has_result = 1'b1;
                        n_phase      = PH_START;
                    end
                end
                default: begin
                    n_phase = PH_START;
                end
            endcase

            // buffer ran out with the prefix still open
            if (!w_has_result && w_last) begin
                w_has_result = 1'b1;
                w_status     = ST_TRUNC;
            end

            if (w_last) begin
                n_phase = PH_START;
            end else if (w_has_result && w_status != ST_OK) begin
                n_discarding = 1'b1;
                n_phase      = PH_START;
            end
        end
    end

    always_comb begin
        w_result.path_id       = n_path_id;
        w_result.prefix_width  = n_width;
        w_result.prefix_high   = (w_status == ST_OK) ? n_prefix[127:64] : 64'd0;
        w_result.prefix_low    = (w_status == ST_OK) ? n_prefix[63:0]   : 64'd0;
        w_result.status        = w_status;
        w_result.end_of_buffer = w_last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_START;
            r_count      <= '0;
            r_path_id    <= '0;
            r_width      <= '0;
            r_prefix     <= '0;
            r_discarding <= 1'b0;
        end else if (w_accept) begin
            r_phase      <= n_phase;
            r_count      <= n_count;
            r_path_id    <= n_path_id;
            r_width      <= n_width;
            r_prefix     <= n_prefix;
            r_discarding <= n_discarding;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_ready) begin
            r_out_valid <= w_accept && w_has_result;
        end
    end

    // hold the payload while the consumer stalls
    always_ff @(posedge i_clk) begin
        if (w_accept && w_has_result) begin
            r_out <= w_result;
        end
    end

    assign o_prefix.valid         = r_out_valid;
    assign o_prefix.path_id       = r_out.path_id;
    assign o_prefix.prefix_width  = r_out.prefix_width;
    assign o_prefix.prefix_high   = r_out.prefix_high;
    assign o_prefix.prefix_low    = r_out.prefix_low;
    assign o_prefix.status        = r_out.status;
    assign o_prefix.end_of_buffer = r_out.end_of_buffer;

`ifndef NO_ASSERTIONS
    a_no_result_while_discarding: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && r_discarding) |-> !w_has_result)
        else $error("result produced while discarding");

    a_last_rearms: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && w_last) |=> (r_phase == PH_START && !r_discarding))
        else $error("last word did not re-arm the parser");

    a_prefix_width_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_PREFIX) |-> (r_width != 8'd0 && r_width <= MAX_WIDTH_V6))
        else $error("prefix phase with illegal width");

    a_error_starts_discard: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && w_has_result && w_status != ST_OK && !w_last) |=> r_discarding)
        else $error("error word did not start discarding");
`endif

endmodule

// ----- bench/tb.sv -----
// ----------------------------------------------------------------------------
// tb: self-checking bench for the BGP NLRI prefix parser
// Feeds NLRI buffers byte by byte: a table of hand-picked cases first, then
// random buffers under every family/path-id setting. Mostly well-formed,
// with cut-short buffers, oversize widths and noise mixed in. A local
// byte-walker predicts the prefixes and error reports of each random buffer;
// the table rows carry their own. Results are compared field by field as the
// receiver takes them, with random stalls on both sides and one long hold-off.
// ----------------------------------------------------------------------------
module tb;
    import bnp_pkg::*;

    typedef struct {
        logic       fam;
        logic       ap;
        logic [7:0] data;
        logic       last;
        logic       typed;
        t_result    want;
    } t_probe_row;

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_we;
    logic i_cfg_idx;
    logic i_cfg_wdata;

    bnp_in_if  nlri_bus ();
    bnp_out_if prefix_bus ();

    bgp_nlri_prefix_parser_top u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .i_nlri      (nlri_bus),
        .o_prefix    (prefix_bus)
    );

    // register shadows and byte-walker state, at their reset values
    logic        fam_sel     = 1'b0;
    logic        addpath_on  = 1'b0;
    t_phase      walk_phase  = PH_START;
    logic [4:0]  walk_count  = '0;
    logic [31:0] walk_path   = '0;
    logic [7:0]  walk_width  = '0;
    logic [63:0] walk_high   = '0;
    logic [63:0] walk_low    = '0;
    logic        dropping    = 1'b0;

    t_result pending_prefixes [$];
    int      bytes_sent;
    int      mismatches;
    int      seen_ok;
    int      seen_trunc;
    int      seen_badwidth;
    logic    steady;
    logic    holding_off;

    t_probe_row probe_rows [22] = '{
        '{1'b0, 1'b0, 8'd0,   1'b0, 1'b1, '{32'h0, 8'd0, 64'h0, 64'h0, ST_OK, 1'b0}},
        '{1'b0, 1'b0, 8'd32,  1'b0, 1'b0, '0},
        '{1'b0, 1'b0, 8'hFF,  1'b0, 1'b0, '0},
        '{1'b0, 1'b0, 8'h00,  1'b0, 1'b0, '0},
        '{1'b0, 1'b0, 8'hA5,  1'b0, 1'b0, '0},
        '{1'b0, 1'b0, 8'h5A,  1'b1, 1'b1,
          '{32'h0, 8'd32, 64'hFF00_A55A_0000_0000, 64'h0, ST_OK, 1'b1}},
        '{1'b0, 1'b0, 8'd33,  1'b0, 1'b1, '{32'h0, 8'd33, 64'h0, 64'h0, ST_BADWIDTH, 1'b0}},
        '{1'b0, 1'b0, 8'hFF,  1'b0, 1'b0, '0},
        '{1'b0, 1'b0, 8'h00,  1'b1, 1'b0, '0},
        '{1'b0, 1'b0, 8'd255, 1'b1, 1'b1, '{32'h0, 8'd255, 64'h0, 64'h0, ST_BADWIDTH, 1'b1}},
        '{1'b0, 1'b0, 8'd9,   1'b0, 1'b0, '0},
        '{1'b0, 1'b0, 8'hAB,  1'b1, 1'b1, '{32'h0, 8'd9, 64'h0, 64'h0, ST_TRUNC, 1'b1}},
        '{1'b1, 1'b0, 8'd129, 1'b1, 1'b1, '{32'h0, 8'd129, 64'h0, 64'h0, ST_BADWIDTH, 1'b1}},
        '{1'b1, 1'b0, 8'd128, 1'b1, 1'b1, '{32'h0, 8'd128, 64'h0, 64'h0, ST_TRUNC, 1'b1}},
        '{1'b1, 1'b1, 8'hFF,  1'b0, 1'b0, '0},
        '{1'b1, 1'b1, 8'hFF,  1'b0, 1'b0, '0},
        '{1'b1, 1'b1, 8'hFF,  1'b0, 1'b0, '0},
        '{1'b1, 1'b1, 8'hFF,  1'b0, 1'b0, '0},
        '{1'b1, 1'b1, 8'd8,   1'b0, 1'b0, '0},
        '{1'b1, 1'b1, 8'hC0,  1'b1, 1'b1,
          '{32'hFFFF_FFFF, 8'd8, 64'hC000_0000_0000_0000, 64'h0, ST_OK, 1'b1}},
        '{1'b1, 1'b1, 8'h12,  1'b0, 1'b0, '0},
        '{1'b1, 1'b1, 8'h34,  1'b1, 1'b1, '{32'h0000_1234, 8'd0, 64'h0, 64'h0, ST_TRUNC, 1'b1}}
    };

    // Advance the walker by one byte; return 1 with the result when one is due.
    function automatic logic parse_byte(input logic [7:0] b, input logic l,
                                        output t_result r);
        logic       hit;
        logic       grab;
        t_status    st;
        logic [7:0] lim;
        logic [8:0] need;
        int         k;
        hit  = 1'b0;
        grab = 1'b0;
        st   = ST_OK;
        r    = '0;
        lim  = fam_sel ? MAX_WIDTH_V6 : MAX_WIDTH_V4;
        if (dropping) begin
            if (l) begin
                dropping   = 1'b0;
                walk_phase = PH_START;
            end
            return 1'b0;
        end
        case (walk_phase)
            PH_START: begin
                walk_path  = '0;
                walk_width = '0;
                walk_high  = '0;
                walk_low   = '0;
                walk_count = '0;
                if (addpath_on) begin
                    walk_path  = {24'd0, b};
                    walk_count = 5'd1;
                    walk_phase = PH_PATHID;
                end else begin
                    grab = 1'b1;
                end
            end
            PH_PATHID: begin
                walk_path  = {walk_path[23:0], b};
                walk_count = walk_count + 5'd1;
                if (walk_count >= PATH_ID_BYTES) begin
                    walk_count = '0;
                    walk_phase = PH_WIDTH;
                end
            end
            PH_WIDTH: grab = 1'b1;
            default: begin
                need = ({1'b0, walk_width} + 9'd7) >> 3;
                k    = int'(walk_count[3:0]);
                if (k < 8) walk_high = walk_high | (64'(b) << (56 - 8 * k));
                else       walk_low  = walk_low  | (64'(b) << (120 - 8 * k));
                walk_count = walk_count + 5'd1;
                if ({4'd0, walk_count} >= need) begin
                    walk_phase = PH_START;
                    hit        = 1'b1;
                    st         = ST_OK;
                end
            end
        endcase
        if (grab) begin
            walk_width = b;
            if (b > lim) begin
                hit = 1'b1;
                st  = ST_BADWIDTH;
            end else if (b == 8'd0) begin
                hit        = 1'b1;
                st         = ST_OK;
                walk_phase = PH_START;
            end else begin
                walk_phase = PH_PREFIX;
                walk_count = '0;
            end
        end
        if (!hit && l && walk_phase != PH_START) begin
            hit = 1'b1;
            st  = ST_TRUNC;
        end
        if (l) begin
            walk_phase = PH_START;
        end else if (hit && st != ST_OK) begin
            dropping   = 1'b1;
            walk_phase = PH_START;
        end
        if (hit) begin
            r.path_id      = walk_path;
            r.prefix_width = walk_width;
            if (st == ST_OK) begin
                r.prefix_high = walk_high;
                r.prefix_low  = walk_low;
            end
            r.status        = st;
            r.end_of_buffer = l;
        end
        return hit;
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        if (mismatches < 200)
            $display("mismatch at %0t: %s got %h want %h", $time, what, got, want);
        mismatches++;
    endtask

    // Offer one word and hold it until taken; queue what it should produce.
    task automatic put_byte(input logic [7:0] b, input logic l, input logic typed,
                            input t_result typed_want);
        t_result guess;
        logic    hit;
        if (!steady && $urandom_range(99) < 15) begin
            nlri_bus.valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        nlri_bus.valid     <= 1'b1;
        nlri_bus.data_byte <= b;
        nlri_bus.last_byte <= l;
        do @(posedge i_clk); while (nlri_bus.ready !== 1'b1);
        bytes_sent++;
        hit = parse_byte(b, l, guess);
        if (typed)    pending_prefixes.push_back(typed_want);
        else if (hit) pending_prefixes.push_back(guess);
    endtask

    // Drain, let the block settle, then write both registers.
    task automatic reconfigure(input logic fam, input logic ap);
        nlri_bus.valid <= 1'b0;
        while (pending_prefixes.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= CFG_ADDRESS_FAMILY;
        i_cfg_wdata <= fam;
        @(posedge i_clk);
        i_cfg_idx   <= CFG_PATH_IDS;
        i_cfg_wdata <= ap;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        fam_sel    = fam;
        addpath_on = ap;
    endtask

    task automatic send_random_buffer();
        logic [7:0]  bytes_q [$];
        int unsigned lim;
        int unsigned w;
        int unsigned roll;
        int unsigned keep;
        lim  = fam_sel ? MAX_WIDTH_V6 : MAX_WIDTH_V4;
        roll = $urandom_range(99);
        if (roll < 6) begin
            repeat ($urandom_range(1, 6)) bytes_q.push_back(8'($urandom));
        end else begin
            repeat ($urandom_range(1, 4)) begin
                if (addpath_on) repeat (4) bytes_q.push_back(8'($urandom));
                case ($urandom_range(19))
                    0:       w = 0;
                    1:       w = lim;
                    2:       w = $urandom_range(255, lim + 1);
                    default: w = $urandom_range(lim, 1);
                endcase
                bytes_q.push_back(8'(w));
                if (w <= lim) repeat ((w + 7) / 8) bytes_q.push_back(8'($urandom));
            end
            // cut the buffer short now and then
            if (roll < 18 && bytes_q.size() > 1) begin
                keep = $urandom_range(bytes_q.size() - 1, 1);
                while (bytes_q.size() > keep) void'(bytes_q.pop_back());
            end
        end
        foreach (bytes_q[i]) put_byte(bytes_q[i], i == bytes_q.size() - 1, 1'b0, '0);
    endtask

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // receiver: random stalls, none while steady, none taken during hold-off
    initial begin
        prefix_bus.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (holding_off)  prefix_bus.ready <= 1'b0;
            else if (steady)  prefix_bus.ready <= 1'b1;
            else              prefix_bus.ready <= ($urandom_range(99) >= 15);
        end
    end

    // long hold-off so the result register fills and the input stalls
    initial begin
        holding_off = 1'b0;
        while (bytes_sent < 400) @(posedge i_clk);
        holding_off <= 1'b1;
        repeat (300) @(posedge i_clk);
        holding_off <= 1'b0;
    end

    initial begin
        t_result want;
        forever begin
            @(posedge i_clk);
            if (i_rst_n === 1'b1 && prefix_bus.valid === 1'b1 && prefix_bus.ready === 1'b1) begin
                if (pending_prefixes.size() == 0) begin
                    report_mismatch("unexpected result, status", prefix_bus.status, '0);
                end else begin
                    want = pending_prefixes.pop_front();
                    if (prefix_bus.path_id !== want.path_id)
                        report_mismatch("path_id", prefix_bus.path_id, want.path_id);
                    if (prefix_bus.prefix_width !== want.prefix_width)
                        report_mismatch("prefix_width", prefix_bus.prefix_width,
                                        want.prefix_width);
                    if (prefix_bus.prefix_high !== want.prefix_high)
                        report_mismatch("prefix_high", prefix_bus.prefix_high, want.prefix_high);
                    if (prefix_bus.prefix_low !== want.prefix_low)
                        report_mismatch("prefix_low", prefix_bus.prefix_low, want.prefix_low);
                    if (prefix_bus.status !== want.status)
                        report_mismatch("status", prefix_bus.status, want.status);
                    if (prefix_bus.end_of_buffer !== want.end_of_buffer)
                        report_mismatch("end_of_buffer", prefix_bus.end_of_buffer,
                                        want.end_of_buffer);
                    case (want.status)
                        ST_OK:    seen_ok++;
                        ST_TRUNC: seen_trunc++;
                        default:  seen_badwidth++;
                    endcase
                end
            end
        end
    end

    initial begin
        logic fam;
        logic ap;
        int   phase_start;
        i_rst_n            = 1'b0;
        i_cfg_we           = 1'b0;
        i_cfg_idx          = CFG_ADDRESS_FAMILY;
        i_cfg_wdata        = 1'b0;
        nlri_bus.valid     = 1'b0;
        nlri_bus.data_byte = '0;
        nlri_bus.last_byte = 1'b0;
        steady             = 1'b0;
        bytes_sent         = 0;
        mismatches         = 0;
        seen_ok            = 0;
        seen_trunc         = 0;
        seen_badwidth      = 0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (probe_rows[i]) begin
            if (probe_rows[i].fam !== fam_sel || probe_rows[i].ap !== addpath_on)
                reconfigure(probe_rows[i].fam, probe_rows[i].ap);
            put_byte(probe_rows[i].data, probe_rows[i].last, probe_rows[i].typed,
                     probe_rows[i].want);
        end

        // first four phases walk every setting, the rest pick at random
        for (int ph = 0; ph < 8; ph++) begin
            fam = (ph < 4) ? ph[0] : 1'($urandom_range(1));
            ap  = (ph < 4) ? ph[1] : 1'($urandom_range(1));
            reconfigure(fam, ap);
            steady <= (ph == 5);
            phase_start = bytes_sent;
            while (bytes_sent - phase_start < 125) send_random_buffer();
        end

        nlri_bus.valid <= 1'b0;
        while (pending_prefixes.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        $display("tb: %0d bytes sent across IPv4/IPv6 with and without path ids",
                 bytes_sent);
        $display("tb: %0d results checked: %0d complete, %0d truncated, %0d bad width",
                 seen_ok + seen_trunc + seen_badwidth, seen_ok, seen_trunc, seen_badwidth);
        if (mismatches == 0) begin
            $display("tb: clean");
        end else begin
            $display("tb: errors");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("tb: errors");
        $finish;
    end

endmodule

// ----- files.f -----
design/bnp_pkg.sv
design/bnp_in_if.sv
design/bnp_out_if.sv
design/bgp_nlri_prefix_parser_top.sv
bench/tb.sv
